>>> hdl/fxa_pkg.sv
`default_nettype none
package fxa_pkg;
    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_LT = 4'd4, OP_GT = 4'd5, OP_LE = 4'd6, OP_GE = 4'd7,
        OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
        OP_INC = 4'd12, OP_DEC = 4'd13, OP_TOINT = 4'd14, OP_NONE = 4'd15
    } t_op;
    localparam int unsigned OP_BITS  = 4;
    localparam int unsigned OUT_BITS = 32;
endpackage
`default_nettype wire

>>> hdl/fixed_point_q24_8_alu.sv
// Signed fixed-point ALU (default Q24.8), one word in, one word out.
// Slave side: s_axis_tdata = {operand_b, operand_a} (a in bits [31:0]),
//   s_axis_tuser = op (see fxa_pkg::t_op).
// Master side: m_axis_tdata = result_raw, m_axis_tuser = {overflow, compare_true}
//   (compare_true in bit 0).
// Every op runs through the same pipeline: one input register, a chain of
// WORD_BITS+FRAC_BITS divide cells (one quotient bit per cell, per cycle while
// the pipe is not stalled), then rounding/saturation logic in front of the output
// register, so the latency is independent of op. Throughput is one word per cycle
// unless the master side stalls; the divide cell chain sets the latency.
// A stall at the master side freezes the whole pipe (ready = !out_valid or
// m_axis_tready), so no word is lost; at most one word per stage is held.
// Multiply uses one WORD_BITS x WORD_BITS multiplier with a register after it.
// Synchronous active-low reset clears all valid bits; data needs no reset.
`default_nettype none
module fixed_point_q24_8_alu #(
    parameter int unsigned FRAC_BITS = 8,
    parameter int unsigned WORD_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // operand_a[31:0], operand_b[63:32]
    input  wire logic [3:0]  s_axis_tuser,  // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // result_raw
    output logic [1:0]       m_axis_tuser   // compare_true, overflow
);
    localparam int unsigned W  = WORD_BITS;
    localparam int unsigned NB = WORD_BITS + FRAC_BITS;
    localparam int unsigned NS = NB;
    localparam logic signed [W+1:0] MAXV = (W+2)'((64'd1 << (W-1)) - 64'd1);
    localparam logic signed [W+1:0] MINV = -(W+2)'(64'd1 << (W-1));

    logic w_en;
    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    // ---- stage 0: decode and compute everything but division, rounding and saturation
    logic signed [W-1:0] w_a, w_b;
    assign w_a = s_axis_tdata[W-1:0];
    assign w_b = s_axis_tdata[32+W-1:32];
    fxa_pkg::t_op w_op;
    assign w_op = fxa_pkg::t_op'(s_axis_tuser);

    logic [W-1:0] w_ma, w_mb;
    assign w_ma = w_a[W-1] ? W'(-w_a) : W'(w_a);
    assign w_mb = w_b[W-1] ? W'(-w_b) : W'(w_b);

    logic               r_v0;
    fxa_pkg::t_op       r_op0;
    logic               r_neg0, r_bz0, r_cmp0;
    logic signed [W+1:0] r_sum0;
    logic [2*W-1:0]     r_prod0;
    logic [W-1:0]       r_den0;
    logic [NB-1:0]      r_num0;
    logic signed [W-1:0] r_other0;

    logic w_lt, w_eq, w_cmp;
    logic signed [W-1:0] w_other;
    always_comb begin
        w_lt = w_a < w_b;
        w_eq = w_a == w_b;
        w_cmp = 1'b0;
        w_other = '0;
        unique case (w_op)
            fxa_pkg::OP_LT:    w_cmp = w_lt;
            fxa_pkg::OP_GT:    w_cmp = !w_lt && !w_eq;
            fxa_pkg::OP_LE:    w_cmp = w_lt || w_eq;
            fxa_pkg::OP_GE:    w_cmp = !w_lt;
            fxa_pkg::OP_EQ:    w_cmp = w_eq;
            fxa_pkg::OP_NE:    w_cmp = !w_eq;
            fxa_pkg::OP_MIN:   w_other = w_lt ? w_a : w_b;
            fxa_pkg::OP_MAX:   w_other = w_lt ? w_b : w_a;
            fxa_pkg::OP_INC:   w_other = w_a + W'(1);
            fxa_pkg::OP_DEC:   w_other = w_a - W'(1);
            fxa_pkg::OP_TOINT: w_other = w_a >>> FRAC_BITS;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= s_axis_tvalid;
        end
        if (w_en) begin
            r_op0    <= w_op;
            r_neg0   <= w_a[W-1] ^ w_b[W-1];
            r_bz0    <= (w_b == '0);
            r_cmp0   <= w_cmp;
            r_other0 <= w_other;
            r_sum0   <= (w_op == fxa_pkg::OP_SUB)
                        ? ((W+2)'(w_a) - (W+2)'(w_b)) : ((W+2)'(w_a) + (W+2)'(w_b));
            r_prod0  <= w_ma * w_mb;
            r_den0   <= w_mb;
            r_num0   <= {w_ma, FRAC_BITS'(0)};
        end
    end

    // ---- divide chain: side data rides alongside
    typedef struct packed {
        logic                v;
        logic [3:0]          op;
        logic                neg, bz, cmp;
        logic signed [W+1:0] sum;
        logic [2*W-1:0]      prod;
        logic signed [W-1:0] other;
        logic signed [W-1:0] a;
    } t_side;

    logic [W:0]    c_rem [NS+1];
    logic [NB-1:0] c_num [NS+1];
    logic [NB-1:0] c_quo [NS+1];
    logic [W-1:0]  c_den [NS+1];
    t_side         c_sd  [NS+1];

    // raw a is rebuilt from magnitude and sign is not possible cheaply; carry it
    logic signed [W-1:0] r_a0;
    always_ff @(posedge i_clk) if (w_en) r_a0 <= w_a;

    assign c_rem[0] = '0;
    assign c_num[0] = r_num0;
    assign c_quo[0] = '0;
    assign c_den[0] = r_bz0 ? W'(1) : r_den0;
    assign c_sd[0]  = '{v: r_v0, op: r_op0, neg: r_neg0, bz: r_bz0, cmp: r_cmp0,
                        sum: r_sum0, prod: r_prod0, other: r_other0, a: r_a0};

    genvar gi;
    for (gi = 0; gi < NS; gi++) begin : g_chain
        logic [W:0]    w_r;
        logic [NB-1:0] w_n, w_q;
        logic [W-1:0]  w_d;
        fxa_div_cell #(.NB(NB), .DB(W)) u_cell (
            .i_clk(i_clk), .i_rem(c_rem[gi]), .i_num(c_num[gi]), .i_quo(c_quo[gi]),
            .i_den(c_den[gi]), .o_rem(w_r), .o_num(w_n), .o_quo(w_q), .o_den(w_d)
        );
        // cells have no enable; only the side data advances with the pipe, the hold copies freeze cell outputs
        logic [W:0]    r_rh;
        logic [NB-1:0] r_nh, r_qh;
        logic [W-1:0]  r_dh;
        t_side         r_sd;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sd.v <= 1'b0;
            end else if (w_en) begin
                r_sd.v <= c_sd[gi].v;
            end
            if (w_en) begin
                r_sd.op <= c_sd[gi].op; r_sd.neg <= c_sd[gi].neg;
                r_sd.bz <= c_sd[gi].bz; r_sd.cmp <= c_sd[gi].cmp;
                r_sd.sum <= c_sd[gi].sum; r_sd.prod <= c_sd[gi].prod;
                r_sd.other <= c_sd[gi].other; r_sd.a <= c_sd[gi].a;
            end
        end
        // hold copies so a stall keeps the cell outputs frozen
        logic r_first;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_first <= 1'b0;
            else r_first <= w_en;
            if (r_first) begin
                r_rh <= w_r; r_nh <= w_n; r_qh <= w_q; r_dh <= w_d;
            end
        end
        assign c_rem[gi+1] = r_first ? w_r : r_rh;
        assign c_num[gi+1] = r_first ? w_n : r_nh;
        assign c_quo[gi+1] = r_first ? w_q : r_qh;
        assign c_den[gi+1] = r_first ? w_d : r_dh;
        assign c_sd[gi+1]  = r_sd;
    end

    // ---- final stage: rounding, saturation, select
    t_side         w_s;
    logic [NB-1:0] w_q;
    logic [W:0]    w_rm;
    logic [W-1:0]  w_dn;
    assign w_s  = c_sd[NS];
    assign w_q  = c_quo[NS];
    assign w_rm = c_rem[NS];
    assign w_dn = c_den[NS];

    logic [2*W-1:0]      w_pq;
    logic [NB:0]         w_dq;
    logic signed [W+1:0] w_mag_s, w_val;
    logic signed [W-1:0] w_res;
    logic                w_ovf;
    always_comb begin
        w_pq = (w_s.prod + (2*W)'(64'd1 << (FRAC_BITS-1))) >> FRAC_BITS;
        // round half away from zero (on the magnitude): remainder*2 >= den
        w_dq = (NB+1)'(w_q) + (NB+1)'(({w_rm, 1'b0} >= {1'b0, 1'b0, w_dn}) ? 1 : 0);
        w_mag_s = '0;
        if (w_s.op == fxa_pkg::OP_MUL)
            w_mag_s = (w_pq > (2*W)'(64'd1 << W)) ? (W+2)'(64'd1 << W) : (W+2)'(w_pq);
        else
            w_mag_s = (w_dq > (NB+1)'(64'd1 << W)) ? (W+2)'(64'd1 << W) : (W+2)'(w_dq);
        w_val = w_s.neg ? -w_mag_s : w_mag_s;
        if (w_s.op == fxa_pkg::OP_ADD || w_s.op == fxa_pkg::OP_SUB) w_val = w_s.sum;
        w_res = '0;
        w_ovf = 1'b0;
        unique case (w_s.op)
            fxa_pkg::OP_ADD, fxa_pkg::OP_SUB, fxa_pkg::OP_MUL, fxa_pkg::OP_DIV: begin
                if (w_val > MAXV) begin
                    w_res = MAXV[W-1:0]; w_ovf = 1'b1;
                end else if (w_val < MINV) begin
                    w_res = MINV[W-1:0]; w_ovf = 1'b1;
                end else begin
                    w_res = w_val[W-1:0];
                end
                if (w_s.op == fxa_pkg::OP_DIV && w_s.bz) begin
                    w_res = w_s.a; w_ovf = 1'b0;
                end
            end
            default: w_res = w_s.other;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (w_en) begin
            m_axis_tvalid <= w_s.v;
        end
        if (w_en) begin
            m_axis_tdata <= 32'(w_res);
            m_axis_tuser <= {w_ovf, w_s.cmp};
        end
    end

    // compare and overflow never both set
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1])) else $error("flags");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("drop");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready) else $error("ready");
endmodule
`default_nettype wire

>>> hdl/fxa_div_cell.sv
`default_nettype none
// One restoring-division step: shifts in one numerator bit, subtracts divisor.
module fxa_div_cell #(
    parameter int unsigned NB = 40,
    parameter int unsigned DB = 32
) (
    input  wire logic          i_clk,
    input  wire logic [DB:0]   i_rem,
    input  wire logic [NB-1:0] i_num,
    input  wire logic [NB-1:0] i_quo,
    input  wire logic [DB-1:0] i_den,
    output logic      [DB:0]   o_rem,
    output logic      [NB-1:0] o_num,
    output logic      [NB-1:0] o_quo,
    output logic      [DB-1:0] o_den
);
    logic [DB+1:0] w_sh;
    logic [DB+1:0] w_diff;
    assign w_sh   = {i_rem, i_num[NB-1]};
    assign w_diff = w_sh - {2'b00, i_den};
    always_ff @(posedge i_clk) begin
        o_num <= {i_num[NB-2:0], 1'b0};
        o_den <= i_den;
        if (!w_diff[DB+1]) begin
            o_rem <= w_diff[DB:0];
            o_quo <= {i_quo[NB-2:0], 1'b1};
        end else begin
            o_rem <= w_sh[DB:0];
            o_quo <= {i_quo[NB-2:0], 1'b0};
        end
    end
endmodule
`default_nettype wire

>>> dv/fxa_checker.sv
module fxa_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,
    input  wire logic [3:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [31:0] m_axis_tdata,
    input  wire logic [1:0]  m_axis_tuser,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] result_raw;
        logic        compare_true;
        logic        overflow;
    } t_alu_out;

    localparam int FRAC = 8;
    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;

    t_alu_out alu_expected_q[$];
    int       mismatch_count;

    function automatic longint saturate(input longint v, inout logic ovf);
        if (v > MAXV) begin
            ovf = 1'b1;
            return MAXV;
        end
        if (v < MINV) begin
            ovf = 1'b1;
            return MINV;
        end
        return v;
    endfunction

    function automatic t_alu_out alu_predict(input fxa_pkg::t_op op,
                                             input logic [31:0] ra,
                                             input logic [31:0] rb);
        longint a, b, r;
        logic [63:0] ma, mb, p, q;
        logic ovf, cmp, neg;
        t_alu_out o;
        a = longint'(signed'(ra));
        b = longint'(signed'(rb));
        r = 0; ovf = 0; cmp = 0;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        neg = (a < 0) != (b < 0);
        case (op)
            fxa_pkg::OP_ADD: r = saturate(a + b, ovf);
            fxa_pkg::OP_SUB: r = saturate(a - b, ovf);
            fxa_pkg::OP_MUL: begin
                p = ma * mb;
                q = (p + (64'd1 << (FRAC - 1))) >> FRAC;
                r = saturate(neg ? -longint'(q) : longint'(q), ovf);
            end
            fxa_pkg::OP_DIV: begin
                if (b == 0) begin
                    r = a;
                end else begin
                    q = (2 * (ma << FRAC) + mb) / (2 * mb);
                    r = saturate(neg ? -longint'(q) : longint'(q), ovf);
                end
            end
            fxa_pkg::OP_LT: cmp = a < b;
            fxa_pkg::OP_GT: cmp = a > b;
            fxa_pkg::OP_LE: cmp = a <= b;
            fxa_pkg::OP_GE: cmp = a >= b;
            fxa_pkg::OP_EQ: cmp = a == b;
            fxa_pkg::OP_NE: cmp = a != b;
            fxa_pkg::OP_MIN: r = (b < a) ? b : a;
            fxa_pkg::OP_MAX: r = (a < b) ? b : a;
            fxa_pkg::OP_INC: r = longint'(signed'(ra + 32'd1));
            fxa_pkg::OP_DEC: r = longint'(signed'(ra - 32'd1));
            fxa_pkg::OP_TOINT: r = a >>> FRAC;
            default: r = 0;
        endcase
        o.result_raw = r[31:0];
        o.compare_true = cmp;
        o.overflow = ovf;
        return o;
    endfunction

    assign o_fail_count = mismatch_count;

    always @(posedge i_clk) begin
        t_alu_out want;
        if (!i_rst_n) begin
            mismatch_count <= 0;
            o_pending <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                alu_expected_q.push_back(alu_predict(fxa_pkg::t_op'(s_axis_tuser),
                    s_axis_tdata[31:0], s_axis_tdata[63:32]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (alu_expected_q.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected result word %h", m_axis_tdata);
                end else begin
                    want = alu_expected_q.pop_front();
                    if (want.result_raw !== m_axis_tdata ||
                        want.compare_true !== m_axis_tuser[0] ||
                        want.overflow !== m_axis_tuser[1]) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display("mismatch: exp res %h cmp %b ovf %b, got %h %b %b",
                                want.result_raw, want.compare_true, want.overflow,
                                m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
                    end
                end
            end
            o_pending <= alu_expected_q.size();
        end
    end
endmodule

>>> dv/fixed_point_q24_8_alu_tb.sv
module fixed_point_q24_8_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 42;
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // operand_a[31:0], operand_b[63:32]
    logic [3:0]  s_axis_tuser;   // op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // result_raw
    logic [1:0]  m_axis_tuser;   // compare_true, overflow
    int          fail_count;
    int          pending;
    int          cycle_count;
    logic        long_hold;      // receiver held off while sender keeps going

    fixed_point_q24_8_alu dut (.*);

    fxa_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .m_axis_tuser, .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("fixed_point_q24_8_alu_tb NOT OK");
                $finish;
            end
        end
    end

    // Receiver: always ready, mostly ready or mostly stalled in turn, fixed-length hold-off when asked.
    initial begin
        int mode;
        m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            mode = (cycle_count / 500) % 3;
            if (long_hold)
                m_axis_tready <= 0;
            else if (mode == 0)
                m_axis_tready <= 1;
            else if (mode == 1)
                m_axis_tready <= ($urandom_range(3, 0) != 0);
            else
                m_axis_tready <= ($urandom_range(3, 0) == 0);
        end
    end

    // Edge-heavy operand picker: extremes, small fixed and small random values, shifted and full random.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7, 0))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(2, 0)) - 32'd1;
            3: return 32'(signed'($urandom_range(4000, 0)) - 2000);
            4: return $urandom() >> $urandom_range(31, 0);
            5: return -($urandom() >> $urandom_range(31, 0));
            default: return $urandom();
        endcase
    endfunction

    // Offers one word at once (callers sit on a falling edge) and waits for acceptance.
    task automatic send_word(input fxa_pkg::t_op op, input logic [31:0] a,
                             input logic [31:0] b);
        s_axis_tvalid <= 1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {b, a};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        s_axis_tvalid <= 0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] va, vb;
        int burst;
        i_rst_n = 0;
        long_hold = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = fxa_pkg::OP_ADD;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: every op on extremes, divide by zero, wrap of inc and dec,
        // unused selector, halves in rounding.
        for (int k = 0; k <= 15; k++)
            send_word(fxa_pkg::t_op'(k), 32'h7fff_ffff, 32'h8000_0000);
        send_word(fxa_pkg::OP_DIV, 32'h0000_1234, 32'h0);
        send_word(fxa_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0001);
        send_word(fxa_pkg::OP_INC, 32'h7fff_ffff, 32'h0);
        send_word(fxa_pkg::OP_DEC, 32'h8000_0000, 32'h0);
        send_word(fxa_pkg::OP_MUL, 32'h0000_0080, 32'hffff_ff01);
        send_word(fxa_pkg::OP_MUL, 32'hffff_ff80, 32'h0000_0001);
        send_word(fxa_pkg::OP_DIV, 32'h0000_0001, 32'h0000_0200);
        send_word(fxa_pkg::OP_TOINT, 32'hffff_ff01, 32'h0);
        send_word(fxa_pkg::OP_EQ, 32'h8000_0000, 32'h8000_0000);
        drain();

        // Long receiver hold-off while the sender keeps offering words.
        fork
            begin
                long_hold = 1;
                repeat (3 * LATENCY) @(negedge i_clk);
                long_hold = 0;
            end
            repeat (60) send_word(fxa_pkg::t_op'($urandom_range(15, 0)), pick_operand(),
                                  pick_operand());
        join
        drain();

        // Random bursts with random gaps.
        for (int n = 0; n < 515; ) begin
            burst = $urandom_range(20, 1);
            for (int j = 0; j < burst; j++) begin
                va = pick_operand();
                vb = pick_operand();
                send_word(fxa_pkg::t_op'($urandom_range(15, 0)), va, vb);
                n++;
            end
            if ($urandom_range(3, 0) == 0)
                idle_cycles($urandom_range(8, 1));
        end

        drain();
        repeat (LATENCY + 10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("fixed_point_q24_8_alu_tb OK");
        else
            $display("fixed_point_q24_8_alu_tb NOT OK");
        $finish;
    end
endmodule
